FILE: rtl/core/fwcs_pkg.sv
`default_nettype none

package fwcs_pkg;

    // event codes carried in the input tuser
    typedef enum logic [2:0] {
        OP_OBSERVE    = 3'd0,
        OP_DISCONNECT = 3'd1,
        OP_POLL       = 3'd2,
        OP_CAPTURE    = 3'd3,
        OP_UNSTABLE   = 3'd4,
        OP_QUEUE_FAIL = 3'd5,
        OP_QUEUED     = 3'd6,
        OP_DONE       = 3'd7
    } t_opcode;

    // poll action codes
    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_CAPTURE = 2'd1,
        ACT_QUEUE   = 2'd2
    } t_action;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_CRIT_SETTLE    = 3'd0,
        CFG_DISC_SETTLE    = 3'd1,
        CFG_USAGE_LONG     = 3'd2,
        CFG_UNSTABLE_BASE  = 3'd3,
        CFG_UNSTABLE_MAX   = 3'd4,
        CFG_QUEUE_RETRY    = 3'd5,
        CFG_FAILURE_BASE   = 3'd6,
        CFG_FAILURE_MAX    = 3'd7
    } t_cfg_idx;

    localparam int CFG_NUM     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_W       = 24;
    localparam int TIME_W      = 32;
    localparam int GEN_W       = 32;
    localparam int CNT_W       = 16;
    localparam int OPCODE_W    = 3;
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 136;

    // register values after reset
    localparam logic [CFG_W-1:0] RST_CRIT_SETTLE   = 24'd1000;
    localparam logic [CFG_W-1:0] RST_DISC_SETTLE   = 24'd2000;
    localparam logic [CFG_W-1:0] RST_USAGE_LONG    = 24'd600000;
    localparam logic [CFG_W-1:0] RST_UNSTABLE_BASE = 24'd100;
    localparam logic [CFG_W-1:0] RST_UNSTABLE_MAX  = 24'd10000;
    localparam logic [CFG_W-1:0] RST_QUEUE_RETRY   = 24'd1000;
    localparam logic [CFG_W-1:0] RST_FAILURE_BASE  = 24'd1000;
    localparam logic [CFG_W-1:0] RST_FAILURE_MAX   = 24'd60000;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // backoff step: jump to the ceiling once at or above half of it
    function automatic logic [CFG_W-1:0] double_capped(
        input logic [CFG_W-1:0] v,
        input logic [CFG_W-1:0] cap
    );
        if (v >= (cap >> 1)) begin
            return cap;
        end
        return {v[CFG_W-2:0], 1'b0};
    endfunction

    // saturating counter step
    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        if (c != CNT_MAX) begin
            return c + 1'b1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/flash_write_coalescing_scheduler_unit.sv
`default_nettype none

// path: a taken input beat waits in the input register, then one pass of logic
// writes its result beat into the result register, which offers it
// throughput: one event per cycle while results are taken, one update pass on state
// reset: synchronous active low; clears flags, deadline, counters and generations,
// reloads configuration defaults and both backoff delays with their base values
module flash_write_coalescing_scheduler_unit (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // input event stream
    input  wire                                 i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // fields from bit 0: now_ms[31:0], dirty_critical, dirty_usage,
    // dirty_generation[31:0], link_connected, encode_ok, write_ok,
    // snapshot_generation[31:0], zero fill
    input  wire  [fwcs_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // fields from bit 0: opcode[2:0]
    input  wire  [fwcs_pkg::OPCODE_W-1:0]       i_s_axis_tuser,
    // result stream
    output logic                                o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    // fields from bit 0: action[1:0], delay_ms[31:0], capture_accepted,
    // is_pending, is_in_flight, critical_flag, usage_flag, store_gen[31:0],
    // write_gen[31:0], success_count[15:0], failure_count[15:0], zero fill
    output logic [fwcs_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // configuration write channel
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [fwcs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [fwcs_pkg::CFG_W-1:0]          i_cfg_data
);
    import fwcs_pkg::*;

    // configuration registers
    logic [CFG_W-1:0]       r_cfg [CFG_NUM];

    // input register
    logic                   r_in_valid;
    logic [IN_TDATA_W-1:0]  r_in_data;
    logic [OPCODE_W-1:0]    r_in_op;

    // result register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // scheduler state
    logic                   r_pending,    n_pending;
    logic                   r_in_flight,  n_in_flight;
    logic                   r_dl_valid,   n_dl_valid;
    logic [TIME_W-1:0]      r_dl_time,    n_dl_time;
    logic                   r_retry,      n_retry;
    logic [CFG_W-1:0]       r_unstable,   n_unstable;
    logic [CFG_W-1:0]       r_failure,    n_failure;
    logic [GEN_W-1:0]       r_capt_gen,   n_capt_gen;
    logic [GEN_W-1:0]       r_rep_gen,    n_rep_gen;
    logic                   r_crit,       n_crit;
    logic                   r_use,        n_use;
    logic [CNT_W-1:0]       r_ok_cnt,     n_ok_cnt;
    logic [CNT_W-1:0]       r_bad_cnt,    n_bad_cnt;

    // unpacked event fields
    t_opcode                w_op;
    logic [TIME_W-1:0]      w_now;
    logic                   w_dc;
    logic                   w_du;
    logic [GEN_W-1:0]       w_dgen;
    logic                   w_conn;
    logic                   w_enc;
    logic                   w_wok;
    logic [GEN_W-1:0]       w_sgen;

    logic                   w_advance;
    logic [TIME_W-1:0]      w_diff_old;
    logic [CFG_W-1:0]       w_obs_c;
    logic [TIME_W-1:0]      w_earlier;
    logic                   w_arm_en;
    logic [CFG_W-1:0]       w_arm_c;
    logic                   w_accepted;
    logic [TIME_W-1:0]      w_delta;
    logic                   w_reached;
    t_action                w_action;
    logic [TIME_W-1:0]      w_delay;
    logic [GEN_W-1:0]       w_write_gen;

    assign w_op   = t_opcode'(r_in_op);
    assign w_now  = r_in_data[31:0];
    assign w_dc   = r_in_data[32];
    assign w_du   = r_in_data[33];
    assign w_dgen = r_in_data[65:34];
    assign w_conn = r_in_data[66];
    assign w_enc  = r_in_data[67];
    assign w_wok  = r_in_data[68];
    assign w_sgen = r_in_data[100:69];

    // handshake: the input register refills whenever its beat moves on
    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_cfg_ready     = 1'b1;

    // distance from now to the stored deadline, and the observe-case earlier test
    assign w_diff_old = r_dl_time - w_now;
    assign w_obs_c    = w_dc ? r_cfg[CFG_CRIT_SETTLE] :
                        (!w_conn ? r_cfg[CFG_DISC_SETTLE] : r_cfg[CFG_USAGE_LONG]);
    assign w_earlier  = w_diff_old - {8'd0, w_obs_c};

    // event decode and state update
    always_comb begin
        n_pending   = r_pending;
        n_in_flight = r_in_flight;
        n_dl_valid  = r_dl_valid;
        n_dl_time   = r_dl_time;
        n_retry     = r_retry;
        n_unstable  = r_unstable;
        n_failure   = r_failure;
        n_capt_gen  = r_capt_gen;
        n_rep_gen   = r_rep_gen;
        n_crit      = r_crit;
        n_use       = r_use;
        n_ok_cnt    = r_ok_cnt;
        n_bad_cnt   = r_bad_cnt;
        w_arm_en    = 1'b0;
        w_arm_c     = '0;
        w_accepted  = 1'b0;

        unique case (w_op)
            OP_OBSERVE: begin
                n_rep_gen = w_dgen;
                n_crit    = w_dc || r_retry;
                n_use     = w_du;
                if ((w_dc || w_du) && !r_pending && !r_in_flight) begin
                    w_arm_c = w_obs_c;
                    if (w_dc || !w_conn) begin
                        w_arm_en = !r_dl_valid || !w_earlier[TIME_W-1];
                    end else begin
                        w_arm_en = !r_dl_valid;
                    end
                end
            end
            OP_DISCONNECT: begin
                n_rep_gen = w_dgen;
                n_crit    = w_dc || r_retry;
                n_use     = w_du;
                if ((w_dc || w_du) && !r_pending && !r_in_flight) begin
                    w_arm_en = 1'b1;
                    w_arm_c  = r_cfg[CFG_DISC_SETTLE];
                end
            end
            OP_POLL: begin
            end
            OP_CAPTURE: begin
                if (!r_pending && !r_in_flight && w_enc) begin
                    n_capt_gen = w_sgen;
                    n_rep_gen  = w_sgen;
                    n_pending  = 1'b1;
                    n_dl_valid = 1'b0;
                    n_unstable = r_cfg[CFG_UNSTABLE_BASE];
                    w_accepted = 1'b1;
                end
            end
            OP_UNSTABLE: begin
                w_arm_en   = 1'b1;
                w_arm_c    = r_unstable;
                n_unstable = double_capped(r_unstable, r_cfg[CFG_UNSTABLE_MAX]);
            end
            OP_QUEUE_FAIL: begin
                if (r_in_flight) begin
                    n_in_flight = 1'b0;
                    n_pending   = 1'b1;
                end
                w_arm_en = 1'b1;
                w_arm_c  = r_cfg[CFG_QUEUE_RETRY];
            end
            OP_QUEUED: begin
                if (r_pending) begin
                    n_pending   = 1'b0;
                    n_in_flight = 1'b1;
                    n_dl_valid  = 1'b0;
                end
            end
            OP_DONE: begin
                if (r_in_flight) begin
                    n_in_flight = 1'b0;
                    n_rep_gen   = w_dgen;
                    n_use       = w_du;
                    if (w_wok) begin
                        n_ok_cnt  = bump(r_ok_cnt);
                        n_failure = r_cfg[CFG_FAILURE_BASE];
                        n_retry   = 1'b0;
                        n_crit    = w_dc;
                        if (!w_dc && !w_du) begin
                            n_dl_valid = 1'b0;
                        end else begin
                            // deadline at now
                            w_arm_en = 1'b1;
                        end
                    end else begin
                        n_bad_cnt = bump(r_bad_cnt);
                        n_retry   = 1'b1;
                        n_crit    = 1'b1;
                        n_failure = double_capped(r_failure, r_cfg[CFG_FAILURE_MAX]);
                        w_arm_en  = 1'b1;
                        // long usage delay wins only if it is not later
                        if (!w_dc && w_conn && (r_failure >= r_cfg[CFG_USAGE_LONG])) begin
                            w_arm_c = r_cfg[CFG_USAGE_LONG];
                        end else begin
                            w_arm_c = r_failure;
                        end
                    end
                end
            end
        endcase

        // arming sets the deadline relative to now
        w_delta = w_diff_old;
        if (w_arm_en) begin
            n_dl_valid = 1'b1;
            n_dl_time  = w_now + {8'd0, w_arm_c};
            w_delta    = {8'd0, w_arm_c};
        end
    end

    // poll result after the event, from the deadline's distance to now
    assign w_reached = (w_delta == '0) ||
                       (w_delta[TIME_W-1] && (w_delta[TIME_W-2:0] != '0));

    always_comb begin
        if (n_pending) begin
            w_action = (!n_dl_valid || w_reached) ? ACT_QUEUE : ACT_NONE;
        end else if (n_in_flight || (!n_crit && !n_use)) begin
            w_action = ACT_NONE;
        end else begin
            w_action = (n_dl_valid && w_reached) ? ACT_CAPTURE : ACT_NONE;
        end

        if (!n_dl_valid) begin
            w_delay = '1;
        end else if (w_reached) begin
            w_delay = '0;
        end else begin
            w_delay = w_delta;
        end
    end

    assign w_write_gen = n_in_flight ? n_capt_gen : '0;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[CFG_CRIT_SETTLE]   <= RST_CRIT_SETTLE;
            r_cfg[CFG_DISC_SETTLE]   <= RST_DISC_SETTLE;
            r_cfg[CFG_USAGE_LONG]    <= RST_USAGE_LONG;
            r_cfg[CFG_UNSTABLE_BASE] <= RST_UNSTABLE_BASE;
            r_cfg[CFG_UNSTABLE_MAX]  <= RST_UNSTABLE_MAX;
            r_cfg[CFG_QUEUE_RETRY]   <= RST_QUEUE_RETRY;
            r_cfg[CFG_FAILURE_BASE]  <= RST_FAILURE_BASE;
            r_cfg[CFG_FAILURE_MAX]   <= RST_FAILURE_MAX;
        end else if (i_cfg_valid) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_data <= i_s_axis_tdata;
            r_in_op   <= i_s_axis_tuser;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= {1'b0, n_bad_cnt, n_ok_cnt, w_write_gen, n_rep_gen,
                           n_use, n_crit, n_in_flight, n_pending, w_accepted,
                           w_delay, w_action};
        end
    end

    // scheduler state, updated once per event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= 1'b0;
            r_in_flight <= 1'b0;
            r_dl_valid  <= 1'b0;
            r_dl_time   <= '0;
            r_retry     <= 1'b0;
            r_unstable  <= RST_UNSTABLE_BASE;
            r_failure   <= RST_FAILURE_BASE;
            r_capt_gen  <= '0;
            r_rep_gen   <= '0;
            r_crit      <= 1'b0;
            r_use       <= 1'b0;
            r_ok_cnt    <= '0;
            r_bad_cnt   <= '0;
        end else if (w_advance) begin
            r_pending   <= n_pending;
            r_in_flight <= n_in_flight;
            r_dl_valid  <= n_dl_valid;
            r_dl_time   <= n_dl_time;
            r_retry     <= n_retry;
            r_unstable  <= n_unstable;
            r_failure   <= n_failure;
            r_capt_gen  <= n_capt_gen;
            r_rep_gen   <= n_rep_gen;
            r_crit      <= n_crit;
            r_use       <= n_use;
            r_ok_cnt    <= n_ok_cnt;
            r_bad_cnt   <= n_bad_cnt;
        end
    end

endmodule

`default_nettype wire
